/* rtl/core/ceq_pkg.sv */
package ceq_pkg;

    // queue geometry
    localparam int QDEPTH = 16;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // entry flag bits
    localparam int FLAG_TEL = 0;
    localparam int FLAG_RSY = 1;

    typedef enum logic [2:0] {
        K_PUB_TEL   = 3'd0,
        K_PUB_STATE = 3'd1,
        K_DEQUEUE   = 3'd2,
        K_OVF_RSY   = 3'd3,
        K_QUE_RSY   = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        ST_ENQUEUED  = 4'd0,
        ST_COALESCED = 4'd1,
        ST_DROPPED   = 4'd2,
        ST_RSY_REQ   = 4'd3,
        ST_EVENT     = 4'd4,
        ST_RESYNC    = 4'd5,
        ST_EMPTY     = 4'd6,
        ST_EXHAUSTED = 4'd7,
        ST_DONE      = 4'd8
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SH_RD,
        S_SH_WR,
        S_PUSH,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  name_id;
        logic [63:0] revision;
        logic [15:0] payload_handle;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] seq;
        logic [63:0] out_revision;
        logic [7:0]  out_name_id;
        logic        out_is_telemetry;
        logic [15:0] out_payload_handle;
        logic [31:0] dropped_count;
    } t_out_beat;

    typedef struct packed {
        logic [1:0]  flags;
        logic [7:0]  name;
        logic [63:0] rev;
        logic [15:0] pay;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // memory port controls driven by the sequencer
    typedef struct packed {
        logic           we;
        logic [QAW-1:0] waddr;
        logic [QAW-1:0] raddr;
    } t_ram_ctl;

endpackage

/* rtl/core/ceq_entry_ram.sv */
module ceq_entry_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/coalescing_event_queue_core.sv */
// channel  | direction | handshake                  | payload
// in       | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_beat)
// out      | output    | o_out_valid / i_out_ready  | o_out_data (t_out_beat)
// cfg      | input     | i_cfg_we                   | i_cfg_data (capacity)
//
// one item at a time: accept, a scan of the filled entries, a decide step, then a
// read and a write step per entry moved up on a removal, a tail write and a finish
// step; a new item is accepted only after the finish of the last one.
// the scan and the shift share the single read port of the entry memory.
// synchronous active-low reset; entry memory is not cleared, no warm-up pass.
// a result waiting on out stalls only the finish of the next item.
module coalescing_event_queue_core
    import ceq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data,
    input  logic      i_cfg_we,
    input  logic [4:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [4:0]     r_capacity;
    logic [QCW-1:0] r_fill;
    logic           r_armed;
    logic [63:0]    r_rsy_rev;
    logic [63:0]    r_next_seq;
    logic [31:0]    r_drop;

    t_in_beat       r_item;
    logic [QCW-1:0] r_idx;
    logic           r_rdv;
    logic [QAW-1:0] r_rdi;
    logic           r_found;
    logic [QAW-1:0] r_pos;
    logic [63:0]    r_max;
    t_entry         r_head;

    logic [QAW-1:0] r_sh;
    logic [QCW-1:0] r_sh_last;
    logic           r_push;
    t_entry         r_push_ent;
    logic [QAW-1:0] r_push_addr;
    t_out_beat      r_res;

    logic      r_out_valid;
    t_out_beat r_out;

    t_ram_ctl         ram_ctl;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry           rd_ent;
    t_entry           wr_ent;

    logic           in_fire;
    logic           scan_issue;
    logic           scan_match;
    logic [QCW-1:0] cap_eff;
    logic           full;

    // decision of the current item
    logic           p_rm;
    logic [QAW-1:0] p_pos;
    logic           p_push;
    t_entry         p_ent;
    logic           p_inv;
    logic           p_drop_inc;
    logic           p_take;
    logic           p_clr_arm;
    t_out_beat      p_res;
    logic [31:0]    drop_next;

    assign in_fire    = i_in_valid && o_in_ready;
    assign rd_ent     = t_entry'(ram_rdata);
    assign scan_issue = (r_idx < r_fill);
    assign scan_match = rd_ent.flags[FLAG_TEL] &&
                        (r_item.kind == K_PUB_STATE || rd_ent.name == r_item.name_id);

    // effective capacity clamp
    always_comb begin
        if (r_capacity == 5'd0) begin
            cap_eff = QCW'(1);
        end else if (32'(r_capacity) > QDEPTH) begin
            cap_eff = QCW'(QDEPTH);
        end else begin
            cap_eff = QCW'(r_capacity);
        end
    end

    assign full = (r_fill >= cap_eff);

    ceq_entry_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QDEPTH),
        .AW   (QAW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_ctl.we),
        .i_waddr(ram_ctl.waddr),
        .i_wdata(wr_ent),
        .i_raddr(ram_ctl.raddr),
        .o_rdata(ram_rdata)
    );

    // request decision
    always_comb begin
        p_rm       = 1'b0;
        p_pos      = r_pos;
        p_push     = 1'b0;
        p_ent      = '{flags: 2'b01, name: r_item.name_id, rev: r_item.revision,
                       pay: r_item.payload_handle};
        p_inv      = 1'b0;
        p_drop_inc = 1'b0;
        p_take     = 1'b0;
        p_clr_arm  = 1'b0;
        p_res      = '0;
        p_res.status = ST_DONE;
        case (r_item.kind)
            K_PUB_TEL: begin
                if (r_found) begin
                    p_rm   = 1'b1;
                    p_push = 1'b1;
                    p_res.status = ST_COALESCED;
                end else if (full) begin
                    p_drop_inc = 1'b1;
                    p_res.status = ST_DROPPED;
                end else begin
                    p_push = 1'b1;
                    p_res.status = ST_ENQUEUED;
                end
            end
            K_PUB_STATE: begin
                p_ent.flags = 2'b00;
                if (!full) begin
                    p_push = 1'b1;
                    p_res.status = ST_ENQUEUED;
                end else if (r_found) begin
                    p_rm       = 1'b1;
                    p_drop_inc = 1'b1;
                    p_push     = 1'b1;
                    p_res.status = ST_ENQUEUED;
                end else begin
                    p_inv = 1'b1;
                    p_res.status = ST_RSY_REQ;
                end
            end
            K_DEQUEUE: begin
                if (r_armed) begin
                    p_clr_arm = 1'b1;
                    p_take    = 1'b1;
                    if (r_next_seq != 64'd0) begin
                        p_res.status       = ST_RESYNC;
                        p_res.seq          = r_next_seq;
                        p_res.out_revision = r_rsy_rev;
                    end else begin
                        p_res.status = ST_EXHAUSTED;
                    end
                end else if (r_fill != '0) begin
                    p_rm   = 1'b1;
                    p_pos  = '0;
                    p_take = 1'b1;
                    if (r_next_seq == 64'd0) begin
                        p_res.status = ST_EXHAUSTED;
                    end else if (r_head.flags[FLAG_RSY]) begin
                        p_res.status       = ST_RESYNC;
                        p_res.seq          = r_next_seq;
                        p_res.out_revision = r_head.rev;
                    end else begin
                        p_res.status             = ST_EVENT;
                        p_res.seq                = r_next_seq;
                        p_res.out_revision       = r_head.rev;
                        p_res.out_name_id        = r_head.name;
                        p_res.out_is_telemetry   = r_head.flags[FLAG_TEL];
                        p_res.out_payload_handle = r_head.pay;
                    end
                end else begin
                    p_res.status = ST_EMPTY;
                end
            end
            K_OVF_RSY: begin
                p_inv = 1'b1;
            end
            K_QUE_RSY: begin
                p_ent = '{flags: 2'b10, name: 8'd0, rev: r_item.revision, pay: 16'd0};
                if (full) begin
                    p_inv = 1'b1;
                end else begin
                    p_push = 1'b1;
                end
            end
            default: begin
            end
        endcase
        drop_next = (p_drop_inc && r_drop != 32'hFFFF_FFFF) ? r_drop + 32'd1 : r_drop;
        p_res.dropped_count = drop_next;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!scan_issue && !r_rdv) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (p_rm && ({1'b0, p_pos} + QCW'(1) < r_fill)) begin
                    n_state = S_SH_RD;
                end else if (p_push) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SH_RD: begin
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                if ({1'b0, r_sh} + QCW'(2) < r_sh_last + QCW'(1)) begin
                    n_state = S_SH_RD;
                end else if (r_push) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_PUSH: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        ram_ctl.we    = 1'b0;
        ram_ctl.waddr = r_sh;
        ram_ctl.raddr = r_idx[QAW-1:0];
        wr_ent        = rd_ent;
        case (r_state)
            S_SH_RD: begin
                ram_ctl.raddr = r_sh + QAW'(1);
            end
            S_SH_WR: begin
                ram_ctl.we = 1'b1;
            end
            S_PUSH: begin
                ram_ctl.we    = 1'b1;
                ram_ctl.waddr = r_push_addr;
                wr_ent        = r_push_ent;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= 5'd16;
            r_fill      <= '0;
            r_armed     <= 1'b0;
            r_rsy_rev   <= 64'd0;
            r_next_seq  <= 64'd1;
            r_drop      <= 32'd0;
            r_rdv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (r_state == S_SCAN) begin
                r_rdv <= scan_issue;
            end else begin
                r_rdv <= 1'b0;
            end
            // queue bookkeeping on decide
            if (r_state == S_DECIDE) begin
                r_drop <= drop_next;
                if (p_take && r_next_seq != 64'd0) begin
                    r_next_seq <= r_next_seq + 64'd1;
                end
                if (p_clr_arm) begin
                    r_armed   <= 1'b0;
                    r_rsy_rev <= 64'd0;
                end
                if (p_inv) begin
                    r_fill  <= '0;
                    r_armed <= 1'b1;
                    if (r_max > r_rsy_rev) begin
                        r_rsy_rev <= r_max;
                    end
                end else if (p_rm) begin
                    r_fill <= r_fill - QCW'(1);
                end
            end
            if (r_state == S_PUSH) begin
                r_fill <= r_fill + QCW'(1);
            end
            // output register
            if (r_state == S_FIN && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item  <= i_in_data;
                r_idx   <= '0;
                r_found <= 1'b0;
                r_max   <= i_in_data.revision;
            end
            S_SCAN: begin
                if (scan_issue) begin
                    r_idx <= r_idx + QCW'(1);
                end
                r_rdi <= r_idx[QAW-1:0];
                if (r_rdv) begin
                    if (r_rdi == '0) begin
                        r_head <= rd_ent;
                    end
                    if (scan_match && !r_found) begin
                        r_found <= 1'b1;
                        r_pos   <= r_rdi;
                    end
                    if (rd_ent.rev > r_max) begin
                        r_max <= rd_ent.rev;
                    end
                end
            end
            S_DECIDE: begin
                r_sh        <= p_pos;
                r_sh_last   <= r_fill - QCW'(1);
                r_push      <= p_push;
                r_push_ent  <= p_ent;
                r_push_addr <= p_rm ? (r_fill[QAW-1:0] - QAW'(1)) : r_fill[QAW-1:0];
                r_res       <= p_res;
            end
            S_SH_WR: begin
                r_sh <= r_sh + QAW'(1);
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= QDEPTH)
        else $error("fill count beyond queue depth");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == S_SCAN)
        else $error("accepted beat did not start a scan");

    a_arm_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_armed) |-> $past(r_state) == S_DECIDE && $past(r_item.kind) == K_DEQUEUE)
        else $error("pending resync cleared without a dequeue");

    a_seq_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_seq == 64'd0 |=> r_next_seq == 64'd0)
        else $error("exhausted sequence restarted");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_ctl.we |-> r_state == S_SH_WR || r_state == S_PUSH)
        else $error("entry write outside shift or push");
`endif

endmodule
